[rtl/pic_pkg.sv]
package pic_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_LINE  = 2'd2,
    OP_ACK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_ICW2  = 2'd0,
    PH_ICW3  = 2'd1,
    PH_ICW4  = 2'd2,
    PH_READY = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    OCW2_ROT_AEOI_CLR = 3'd0,
    OCW2_EOI          = 3'd1,
    OCW2_NOP          = 3'd2,
    OCW2_SEOI         = 3'd3,
    OCW2_ROT_AEOI_SET = 3'd4,
    OCW2_ROT_EOI      = 3'd5,
    OCW2_SET_PRI      = 3'd6,
    OCW2_ROT_SEOI     = 3'd7
  } ocw2_t;

  typedef enum logic [1:0] {
    RSEL_NONE0 = 2'd0,
    RSEL_NONE1 = 2'd1,
    RSEL_IRR   = 2'd2,
    RSEL_ISR   = 2'd3
  } rsel_t;

  localparam logic [7:0] CALL_OPCODE = 8'hcd;
  localparam logic [7:0] POLL_FLAG   = 8'h80;
  localparam logic [7:0] OCW3_MASK   = 8'h98;
  localparam logic [7:0] OCW3_MATCH  = 8'h08;
  localparam logic [7:0] OCW2_MASK   = 8'h18;
  localparam logic [7:0] VBASE_MASK  = 8'hf8;
  localparam logic [7:0] SPURIOUS    = 8'h07;
  localparam logic [2:0] RSEL_RESET  = 3'd2;

  typedef struct packed {
    op_t        operation;
    logic       port_offset;
    logic [7:0] write_data;
    logic [2:0] irq_number;
    logic       irq_level;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       int_out;
    logic       cascade_active;
    logic [2:0] cascade_id;
  } res_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] level;
  } level_t;

endpackage

[rtl/pic_resolve.sv]
module pic_resolve (
  input  logic [2:0]      base,
  input  logic [7:0]      irr,
  input  logic [7:0]      isr,
  input  logic [7:0]      imr,
  input  logic            ready,
  input  logic [7:0]      sfnm_map,
  output pic_pkg::level_t winner
);
  import pic_pkg::*;

  always_comb begin
    logic       done;
    logic [2:0] k;
    done   = 1'b0;
    winner = '0;
    k      = '0;
    for (int i = 0; i < 8; i++) begin
      k = base + 3'(i);
      if (!done) begin
        if (isr[k] && !sfnm_map[k]) begin
          done = 1'b1;
        end else if (ready && irr[k] && !imr[k]) begin
          winner.valid = 1'b1;
          winner.level = k;
          done         = 1'b1;
        end else if (isr[k]) begin
          done = 1'b1;
        end
      end
    end
  end

endmodule

[rtl/pic_core.sv]
module pic_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  pic_pkg::item_t item,
  input  logic           cfg_write,
  input  logic           cfg_data,
  output pic_pkg::res_t  res
);
  import pic_pkg::*;

  logic       is_master;
  phase_t     phase, phase_next;
  logic [7:0] irr, irr_next;
  logic [7:0] isr, isr_next;
  logic [7:0] imr, imr_next;
  logic [7:0] lines, lines_next;
  logic [2:0] base, base_next;
  logic [2:0] rsel, rsel_next;
  logic       ltim, ltim_next;
  logic       adi, adi_next;
  logic       casc_mode, casc_mode_next;
  logic       icw4_needed, icw4_needed_next;
  logic [2:0] call_low, call_low_next;
  logic [7:0] vbase, vbase_next;
  logic [7:0] call_high, call_high_next;
  logic [7:0] slave_map, slave_map_next;
  logic       sfnm, sfnm_next;
  logic       aeoi, aeoi_next;
  logic       x86, x86_next;
  level_t     active, active_next;
  logic [1:0] ack_step, ack_step_next;

  logic       do_resolve;
  level_t     resolved;
  logic [7:0] sfnm_map;

  assign sfnm_map = (is_master && casc_mode_next && sfnm_next) ? slave_map_next : 8'h00;

  pic_resolve u_resolve (
    .base     (base_next),
    .irr      (irr_next),
    .isr      (isr_next),
    .imr      (imr_next),
    .ready    (phase_next == PH_READY),
    .sfnm_map (sfnm_map),
    .winner   (resolved)
  );

  always_comb begin
    logic [7:0] wd;
    logic [2:0] wl;
    logic [7:0] wm;
    logic [7:0] lm;
    logic [2:0] alv;
    logic [7:0] am;
    logic       slave;
    logic       found;
    logic [2:0] k;
    logic [2:0] ksel;
    logic [7:0] rd;

    wd    = item.write_data;
    wl    = wd[2:0];
    wm    = 8'd1 << wl;
    lm    = 8'd1 << item.irq_number;
    alv   = active.valid ? active.level : 3'd7;
    am    = 8'd1 << alv;
    slave = active.valid && casc_mode && is_master && slave_map[alv];
    found = 1'b0;
    k     = '0;
    ksel  = '0;
    rd    = '0;

    phase_next       = phase;
    irr_next         = irr;
    isr_next         = isr;
    imr_next         = imr;
    lines_next       = lines;
    base_next        = base;
    rsel_next        = rsel;
    ltim_next        = ltim;
    adi_next         = adi;
    casc_mode_next   = casc_mode;
    icw4_needed_next = icw4_needed;
    call_low_next    = call_low;
    vbase_next       = vbase;
    call_high_next   = call_high;
    slave_map_next   = slave_map;
    sfnm_next        = sfnm;
    aeoi_next        = aeoi;
    x86_next         = x86;
    ack_step_next    = ack_step;
    do_resolve       = 1'b0;

    unique case (item.operation)
      OP_WRITE: begin
        do_resolve = 1'b1;
        if (!item.port_offset) begin
          if (wd[4]) begin
            imr_next         = '0;
            isr_next         = '0;
            irr_next         = '0;
            ltim_next        = wd[3];
            adi_next         = wd[2];
            casc_mode_next   = !wd[1];
            icw4_needed_next = wd[0];
            call_low_next    = wd[7:5];
            phase_next       = PH_ICW2;
            ack_step_next    = '0;
            base_next        = '0;
            rsel_next        = RSEL_RESET;
          end else if (phase == PH_READY) begin
            if ((wd & OCW3_MASK) == OCW3_MATCH) begin
              rsel_next = wd[2:0];
            end else if ((wd & OCW2_MASK) == 8'h00) begin
              for (int i = 0; i < 8; i++) begin
                k = base + 3'(i);
                if (!found && isr[k]) begin
                  found = 1'b1;
                  ksel  = k;
                end
              end
              unique case (ocw2_t'(wd[7:5]))
                OCW2_ROT_AEOI_CLR: base_next = '0;
                OCW2_EOI, OCW2_ROT_EOI: begin
                  if (found) begin
                    isr_next[ksel] = 1'b0;
                    if (ocw2_t'(wd[7:5]) == OCW2_ROT_EOI) base_next = ksel + 3'd1;
                  end
                end
                OCW2_SEOI: isr_next = isr & ~wm;
                OCW2_ROT_AEOI_SET: base_next = base + 3'd1;
                OCW2_SET_PRI: base_next = wl + 3'd1;
                OCW2_ROT_SEOI: begin
                  if (isr[wl]) begin
                    isr_next  = isr & ~wm;
                    base_next = wl + 3'd1;
                  end
                end
                OCW2_NOP: ;
              endcase
            end
          end
        end else begin
          unique case (phase)
            PH_ICW2: begin
              vbase_next     = wd & VBASE_MASK;
              call_high_next = wd;
              phase_next     = casc_mode ? PH_ICW3 : (icw4_needed ? PH_ICW4 : PH_READY);
            end
            PH_ICW3: begin
              slave_map_next = wd;
              phase_next     = icw4_needed ? PH_ICW4 : PH_READY;
            end
            PH_ICW4: begin
              sfnm_next  = wd[4];
              aeoi_next  = wd[1];
              x86_next   = wd[0];
              phase_next = PH_READY;
            end
            PH_READY: imr_next = wd;
          endcase
        end
      end
      OP_READ: begin
        if (item.port_offset) begin
          rd = imr;
        end else if (rsel[2]) begin
          if (active.valid) begin
            rd = POLL_FLAG | {5'd0, active.level};
            if (!ltim) irr_next = irr & ~am;
            if (!aeoi) isr_next = isr | am;
            do_resolve = 1'b1;
          end
        end else begin
          unique case (rsel_t'(rsel[1:0]))
            RSEL_IRR:               rd = irr;
            RSEL_ISR:               rd = isr & ~imr;
            RSEL_NONE0, RSEL_NONE1: rd = '0;
          endcase
        end
      end
      OP_LINE: begin
        if (item.irq_level) begin
          if (ltim || !lines[item.irq_number]) irr_next = irr | lm;
          lines_next = lines | lm;
        end else begin
          lines_next = lines & ~lm;
          irr_next   = irr & ~lm;
        end
        do_resolve = (ack_step == 2'd0);
      end
      OP_ACK: begin
        if (x86) begin
          if (!active.valid) begin
            rd = vbase + SPURIOUS;
          end else begin
            if (!ltim) irr_next = irr & ~am;
            if (!aeoi) isr_next = isr | am;
            do_resolve = 1'b1;
            rd = vbase + {5'd0, alv};
          end
        end else if (ack_step == 2'd0) begin
          if (active.valid) begin
            if (!ltim) irr_next = irr & ~am;
            isr_next = isr | am;
          end
          ack_step_next = 2'd1;
          rd = CALL_OPCODE;
        end else if (ack_step == 2'd1) begin
          ack_step_next = 2'd2;
          if (adi) rd = {call_low, alv, 2'b00};
          else     rd = {call_low[2:1], alv, 3'b000};
        end else begin
          ack_step_next = 2'd0;
          if (aeoi && active.valid) isr_next = isr & ~am;
          do_resolve = 1'b1;
          rd = call_high;
        end
      end
    endcase

    active_next = do_resolve ? resolved : active;

    res.read_data      = slave && (item.operation == OP_ACK) ? 8'h00 : rd;
    res.int_out        = active_next.valid;
    res.cascade_active = slave && (item.operation == OP_ACK);
    res.cascade_id     = (slave && (item.operation == OP_ACK)) ? alv : 3'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_master   <= 1'b1;
      phase       <= PH_READY;
      irr         <= '0;
      isr         <= '0;
      imr         <= '0;
      lines       <= '0;
      base        <= '0;
      rsel        <= RSEL_RESET;
      ltim        <= 1'b0;
      adi         <= 1'b0;
      casc_mode   <= 1'b0;
      icw4_needed <= 1'b0;
      call_low    <= '0;
      vbase       <= '0;
      call_high   <= '0;
      slave_map   <= '0;
      sfnm        <= 1'b0;
      aeoi        <= 1'b0;
      x86         <= 1'b1;
      active      <= '0;
      ack_step    <= '0;
    end else begin
      if (cfg_write) is_master <= cfg_data;
      if (accept) begin
        phase       <= phase_next;
        irr         <= irr_next;
        isr         <= isr_next;
        imr         <= imr_next;
        lines       <= lines_next;
        base        <= base_next;
        rsel        <= rsel_next;
        ltim        <= ltim_next;
        adi         <= adi_next;
        casc_mode   <= casc_mode_next;
        icw4_needed <= icw4_needed_next;
        call_low    <= call_low_next;
        vbase       <= vbase_next;
        call_high   <= call_high_next;
        slave_map   <= slave_map_next;
        sfnm        <= sfnm_next;
        aeoi        <= aeoi_next;
        x86         <= x86_next;
        active      <= active_next;
        ack_step    <= ack_step_next;
      end
    end
  end

endmodule

[rtl/programmable_interrupt_controller.sv]
// Eight-input interrupt controller in the style of the classic 8259A.
// Input stream: one transaction per bus write, bus read, request line change
// or acknowledge cycle; s_tuser carries the operation code, s_tdata the
// address bit, write byte, line number and line level.
// Output stream: exactly one transaction per input transaction, in order,
// carrying the read or acknowledge byte, the interrupt output after the
// item, and the cascade select for a slave-supplied acknowledge byte.
// cfg_write/cfg_data set the cascade master strap; write it only when idle.
// Each result is registered in the output register, or in the skid register
// if that one is full. Throughput: one transaction per cycle while s_tready
// is high; the whole state update, including the 8-level rotating priority
// resolve, is one pass of logic into the state and output buffer registers.
// A two-entry output buffer (output register plus skid register) lets one
// more input be taken while a result waits; with both full s_tready drops
// until the receiver takes a result.
// Reset (rst, synchronous): controller ready, all masks and requests clear,
// x86 vector mode, master strap set, output buffer empty.
module programmable_interrupt_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // port_offset, write_data[7:0], irq_number[2:0], irq_level
  input  logic [1:0]  s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // read_data[7:0], int_out, cascade_id[2:0]
  output logic        m_tuser,   // cascade_active
  input  logic        cfg_write,
  input  logic        cfg_data
);
  import pic_pkg::*;

  item_t item;
  res_t  res;
  res_t  out_q, skid_q;
  logic  out_valid, skid_valid;
  logic  accept, pop;

  assign item.operation   = op_t'(s_tuser);
  assign item.port_offset = s_tdata[0];
  assign item.write_data  = s_tdata[8:1];
  assign item.irq_number  = s_tdata[11:9];
  assign item.irq_level   = s_tdata[12];

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign pop      = out_valid && m_tready;

  pic_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          out_q      <= skid_q;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= accept;
          if (accept) out_q <= res;
        end
      end else if (accept) begin
        if (!out_valid) begin
          out_q     <= res;
          out_valid <= 1'b1;
        end else begin
          skid_q     <= res;
          skid_valid <= 1'b1;
        end
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, out_q.cascade_id, out_q.int_out, out_q.read_data};
  assign m_tuser  = out_q.cascade_active;

endmodule
